// ===== src/sscod_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and table builders for the sine soft-clip overdrive.
// No dependencies; imported by every module of the block.
package sscod_pkg;

    // Fixed-point settings
    localparam int SCALE_SHIFT     = 8;
    localparam int SINE_TABLE_SIZE = 512;

    // Quarter turn of phase in Q31 and the shift it amounts to after the >>32
    localparam logic [31:0] QUARTER_TURN = 32'h2000_0000;
    localparam int          QTURN_SH     = 32 - $clog2(QUARTER_TURN);

    // Phase index and table bank geometry
    localparam int IDX_W   = $clog2(SINE_TABLE_SIZE);
    localparam int PH_W    = 31 + IDX_W;
    localparam int EVEN_N  = SINE_TABLE_SIZE / 2 + 1;
    localparam int ODD_N   = (SINE_TABLE_SIZE + 1) / 2;
    localparam int EVEN_AW = $clog2(EVEN_N);
    localparam int ODD_AW  = $clog2(ODD_N);

    // Output scaling saturation limits
    localparam int                 SAT_LIM_I = 2 ** (30 - SCALE_SHIFT);
    localparam logic signed [31:0] SAT_LIM   = 32'(SAT_LIM_I);
    localparam logic signed [31:0] Q31_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN   = 32'sh8000_0000;

    // Taylor series constant, pi in Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Configuration port
    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_CLIP_LEVEL  = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_INV_THRESH  = 2'd2,
        REG_VOLUME      = 2'd3
    } t_reg_idx;

    typedef logic signed [31:0] t_q31;

    typedef struct packed {
        logic [30:0] clip_level;
        logic [30:0] threshold;
        logic [30:0] inverse_threshold;
        logic [30:0] volume_scale;
    } t_cfg;

    // Hard clip flags that ride along with each item
    typedef struct packed {
        logic hi;
        logic lo;
    } t_tag;

    typedef t_q31 t_even_tab [EVEN_N];
    typedef t_q31 t_odd_tab  [ODD_N];

    // Sine at table step i, Q31, by fixed-point Taylor series on the first quadrant
    function automatic t_q31 turn_sine(input int unsigned i);
        logic [63:0] u;
        logic [63:0] a;
        logic [63:0] term;
        longint      sum;
        logic        neg;
        int          n;
        u   = ({32'd0, i} << 32) / 64'(SINE_TABLE_SIZE);
        neg = 1'b0;
        if (u >= 64'h8000_0000) begin
            neg = 1'b1;
            u   = u - 64'h8000_0000;
        end
        if (u > 64'h4000_0000) begin
            u = 64'h8000_0000 - u;
        end
        a    = (u * PI_Q30) >> 30;
        sum  = longint'(a);
        term = a;
        for (n = 1; n <= 12; n++) begin
            term = (term * a) >> 31;
            term = term / 64'(2 * n);
            term = (term * a) >> 31;
            term = term / 64'(2 * n + 1);
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum > 64'sh7FFF_FFFF) begin
            sum = 64'sh7FFF_FFFF;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return neg ? -t_q31'(sum[31:0]) : t_q31'(sum[31:0]);
    endfunction

    // Even entries of the full-period table, including the wrap entry
    function automatic t_even_tab build_even();
        t_even_tab tab;
        for (int k = 0; k < EVEN_N; k++) begin
            tab[k] = turn_sine(32'(2 * k));
        end
        return tab;
    endfunction

    // Odd entries of the full-period table
    function automatic t_odd_tab build_odd();
        t_odd_tab tab;
        for (int k = 0; k < ODD_N; k++) begin
            tab[k] = turn_sine(32'(2 * k + 1));
        end
        return tab;
    endfunction

    // Scale the already shifted product up by 2^(SCALE_SHIFT+1), saturating
    function automatic t_q31 qscale_sat(input logic signed [31:0] r);
        if (r >= SAT_LIM) begin
            return Q31_MAX;
        end else if (r < -SAT_LIM) begin
            return Q31_MIN;
        end else begin
            return r <<< (SCALE_SHIFT + 1);
        end
    endfunction

endpackage

// ===== src/sscod_cfg.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers for the sine soft-clip overdrive.
// Depends on sscod_pkg for the register map and the t_cfg bundle.
module sscod_cfg import sscod_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx n_idx;
    logic     n_wr;

    assign pready = 1'b1;
    assign n_idx  = t_reg_idx'(paddr[3:2]);
    assign n_wr   = psel & penable & pwrite & pready;

    // Write the addressed register, masked to 31 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_level        <= 31'h7FFF_FFFF;
            r_cfg.threshold         <= 31'd1288490188;
            r_cfg.inverse_threshold <= 31'd0;
            r_cfg.volume_scale      <= 31'd8388608;
        end else if (n_wr) begin
            case (n_idx)
                REG_CLIP_LEVEL: r_cfg.clip_level        <= pwdata[30:0];
                REG_THRESHOLD:  r_cfg.threshold         <= pwdata[30:0];
                REG_INV_THRESH: r_cfg.inverse_threshold <= pwdata[30:0];
                REG_VOLUME:     r_cfg.volume_scale      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (n_idx)
            REG_CLIP_LEVEL: prdata = {1'b0, r_cfg.clip_level};
            REG_THRESHOLD:  prdata = {1'b0, r_cfg.threshold};
            REG_INV_THRESH: prdata = {1'b0, r_cfg.inverse_threshold};
            REG_VOLUME:     prdata = {1'b0, r_cfg.volume_scale};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sscod_sine.sv =====
`timescale 1ns / 1ps
// Three-stage sine lookup: banked ROM read, two interpolation multiplies, sum.
// Depends on sscod_pkg for the table builders, widths and the t_tag bundle.
module sscod_sine import sscod_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [30:0]      i_frac,
    input  t_tag             i_tag,
    output logic             o_valid,
    output t_q31             o_sin,
    output t_tag             o_tag
);

    // Entries idx and idx+1 always fall in different banks
    localparam t_even_tab EVEN_TAB = build_even();
    localparam t_odd_tab  ODD_TAB  = build_odd();

    logic [IDX_W:0]      n_idx_p1;
    logic [EVEN_AW-1:0]  n_even_addr;
    logic [ODD_AW-1:0]   n_odd_addr;

    logic                r_a_valid;
    t_q31                r_a_even;
    t_q31                r_a_odd;
    logic                r_a_par;
    logic [30:0]         r_a_frac;
    t_tag                r_a_tag;

    t_q31                n_lo;
    t_q31                n_hi;
    logic [31:0]         n_cf;
    logic signed [63:0]  n_s_full;
    logic signed [63:0]  n_q_full;

    logic                r_b_valid;
    logic signed [30:0]  r_b_s;
    logic signed [30:0]  r_b_q;
    t_tag                r_b_tag;

    logic [31:0]         n_sum;

    logic                r_c_valid;
    t_q31                r_c_sin;
    t_tag                r_c_tag;

    // Bank addresses for the entry and its right neighbor
    assign n_idx_p1    = {1'b0, i_idx} + (IDX_W + 1)'(1);
    assign n_even_addr = EVEN_AW'(n_idx_p1 >> 1);
    assign n_odd_addr  = ODD_AW'(i_idx >> 1);

    // Stage A: read both banks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_even <= EVEN_TAB[n_even_addr];
        r_a_odd  <= ODD_TAB[n_odd_addr];
        r_a_par  <= i_idx[0];
        r_a_frac <= i_frac;
        r_a_tag  <= i_tag;
    end

    // Stage B: weight the two neighbors by the fraction
    always_comb begin
        n_lo     = r_a_par ? r_a_odd  : r_a_even;
        n_hi     = r_a_par ? r_a_even : r_a_odd;
        n_cf     = 32'h8000_0000 - {1'b0, r_a_frac};
        n_s_full = $signed({1'b0, n_cf}) * n_lo;
        n_q_full = $signed({1'b0, r_a_frac}) * n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_s   <= n_s_full[62:32];
        r_b_q   <= n_q_full[62:32];
        r_b_tag <= r_a_tag;
    end

    // Stage C: add the halves and double, wrapping to 32 bits
    assign n_sum = {r_b_s[30], r_b_s} + {r_b_q[30], r_b_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_sin <= {n_sum[30:0], 1'b0};
        r_c_tag <= r_b_tag;
    end

    assign o_valid = r_c_valid;
    assign o_sin   = r_c_sin;
    assign o_tag   = r_c_tag;

    // Every item leaves after passing through stages A, B and C
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##3 o_valid)
        else $error("sine item lost in pipeline");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> ##3 !o_valid)
        else $error("sine pipeline produced an item from nothing");

    a_tag_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_tag.hi) |-> ##3 o_tag.hi)
        else $error("clip flag separated from its item");

endmodule

// ===== src/sine_soft_clip_overdrive_top.sv =====
`timescale 1ns / 1ps
// Each item passes registers s1, s2, sine stages A to C, s6, s7 and the output register before o_valid.
// Throughput: one item per cycle; busy never rises and the receiver cannot stall.
// Depth comes from the multiply chain: input scale, phase, banked ROM read,
// two interpolation multiplies, sum, clip-level multiply, volume multiply, output saturation.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module sine_soft_clip_overdrive_top import sscod_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        i_sample_in,
    output logic               o_valid,
    output logic [31:0]        o_sample_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg                n_cfg;
    logic                n_acc;

    logic signed [32:0]  n_x33;
    logic signed [32:0]  n_thr33;
    t_tag                n_s1_tag;
    logic signed [63:0]  n_s1_full;

    logic                r_s1_valid;
    logic [62:0]         r_s1_prod;
    t_tag                r_s1_tag;

    logic signed [31:0]  n_t1;
    t_q31                n_t2;
    logic [PH_W-1:0]     n_p;

    logic                r_s2_valid;
    logic [IDX_W-1:0]    r_s2_idx;
    logic [30:0]         r_s2_frac;
    t_tag                r_s2_tag;

    logic                n_sin_valid;
    t_q31                n_sin;
    t_tag                n_sin_tag;

    logic signed [63:0]  n_s6_full;
    logic                r_s6_valid;
    logic [62:0]         r_s6_prod;
    t_tag                r_s6_tag;

    logic signed [31:0]  n_y;
    logic signed [63:0]  n_s7_full;
    logic                r_s7_valid;
    logic [62:0]         r_s7_prod;
    t_tag                r_s7_tag;

    logic                r_out_valid;
    t_q31                r_out_sample;

    sscod_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (n_cfg)
    );

    // Fully pipelined: always ready
    assign busy  = 1'b0;
    assign n_acc = start & ~busy;

    // Stage 1: clip compare and input normalize multiply
    always_comb begin
        n_x33       = $signed({i_sample_in[31], i_sample_in});
        n_thr33     = $signed({2'b00, n_cfg.threshold});
        n_s1_tag.hi = n_x33 > n_thr33;
        n_s1_tag.lo = n_x33 < -n_thr33;
        n_s1_full   = $signed(i_sample_in) * $signed({1'b0, n_cfg.inverse_threshold});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_acc;
        end
        r_s1_prod <= n_s1_full[62:0];
        r_s1_tag  <= n_s1_tag;
    end

    // Stage 2: quarter-turn scale, wrap phase, split into index and fraction
    always_comb begin
        n_t1 = $signed({r_s1_prod[62:32], 1'b0});
        n_t2 = qscale_sat(n_t1 >>> QTURN_SH);
        n_p  = PH_W'(n_t2[30:0]) * PH_W'(SINE_TABLE_SIZE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_idx  <= n_p[PH_W-1:31];
        r_s2_frac <= n_p[30:0];
        r_s2_tag  <= r_s1_tag;
    end

    // Stages 3 to 5: table lookup with interpolation
    sscod_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_idx   (r_s2_idx),
        .i_frac  (r_s2_frac),
        .i_tag   (r_s2_tag),
        .o_valid (n_sin_valid),
        .o_sin   (n_sin),
        .o_tag   (n_sin_tag)
    );

    // Stage 6: scale the sine by the clip level
    assign n_s6_full = $signed({1'b0, n_cfg.clip_level}) * n_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else begin
            r_s6_valid <= n_sin_valid;
        end
        r_s6_prod <= n_s6_full[62:0];
        r_s6_tag  <= n_sin_tag;
    end

    // Stage 7: pick clipped or shaped value, apply volume
    always_comb begin
        if (r_s6_tag.hi) begin
            n_y = $signed({1'b0, n_cfg.clip_level});
        end else if (r_s6_tag.lo) begin
            n_y = -$signed({1'b0, n_cfg.clip_level});
        end else begin
            n_y = $signed({r_s6_prod[62:32], 1'b0});
        end
        n_s7_full = n_y * $signed({1'b0, n_cfg.volume_scale});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else begin
            r_s7_valid <= r_s6_valid;
        end
        r_s7_prod <= n_s7_full[62:0];
        r_s7_tag  <= r_s6_tag;
    end

    // Stage 8: shift up with saturation and present the item for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s7_valid;
        end
        r_out_sample <= qscale_sat($signed({r_s7_prod[62], r_s7_prod[62:32]}));
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_sample;

    // A sample cannot exceed both clip bounds at once
    a_tag_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_tag.hi && r_s1_tag.lo))
        else $error("both clip flags set");

    // Output is a shifted product unless it saturated high
    a_out_granule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_out[SCALE_SHIFT:0] == '0 || o_sample_out == Q31_MAX))
        else $error("output not aligned to volume shift");

    // Positive clip with a non-negative volume never turns negative
    a_clip_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s7_valid && r_s7_tag.hi) |=> !o_sample_out[31])
        else $error("positive clip produced negative output");

endmodule
